### rtl/heat_stencil_3d_7pt_core_macros.svh
// ----------------------------------------------------------------------------
// heat stencil core assertion macros
// concurrent assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef HEAT_STENCIL_3D_7PT_CORE_MACROS_SVH
`define HEAT_STENCIL_3D_7PT_CORE_MACROS_SVH

`ifndef SYNTH

// property holds at every clock edge outside reset
`define HS3D7_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define HS3D7_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define HS3D7_ASSERT(lbl, clk, rst_n, prop, msg)
`define HS3D7_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/hs3d7_pkg.sv
// ----------------------------------------------------------------------------
// hs3d7_pkg
// shared types and constants of the seven-point heat stencil core
// ----------------------------------------------------------------------------
package hs3d7_pkg;

	localparam int VAL_W  = 24;
	localparam int PART_W = VAL_W + 2;
	localparam int SUM_W  = VAL_W + 3;
	localparam int CFG_W  = 6;

	typedef logic [VAL_W-1:0] val_t;

	// the seven stencil taps around one center cell
	typedef struct packed {
		val_t nb_ip;
		val_t nb_jp;
		val_t nb_kp;
		val_t ctr;
		val_t nb_km;
		val_t nb_jm;
		val_t nb_im;
	} taps_t;

	// per-cell control traveling with the taps
	typedef struct packed {
		logic interior;
		logic last;
	} meta_t;

endpackage

### rtl/hs3d7_ram.sv
// ----------------------------------------------------------------------------
// hs3d7_ram
// single-port synchronous ram, read-first, registered read data
// ----------------------------------------------------------------------------
module hs3d7_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			rdata <= mem[addr];
			if (we) begin
				mem[addr] <= wdata;
			end
		end
	end

endmodule

### rtl/hs3d7_window.sv
// ----------------------------------------------------------------------------
// hs3d7_window
// two-plane sliding window built as ram delay lines, yields the seven taps
// ----------------------------------------------------------------------------
`include "heat_stencil_3d_7pt_core_macros.svh"

module hs3d7_window #(
	parameter int MAX_EDGE = 32,
	localparam int PLANE_DEPTH = MAX_EDGE * MAX_EDGE - MAX_EDGE - 1,
	localparam int ROW_DEPTH = MAX_EDGE - 2,
	localparam int PA_W = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1,
	localparam int RA_W = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 restart,
	input  logic [PA_W-1:0]      pl_last,
	input  logic [RA_W-1:0]      rw_last,
	input  hs3d7_pkg::val_t      din,
	output hs3d7_pkg::taps_t     taps
);

	logic [PA_W-1:0] pp_q;
	logic [RA_W-1:0] rp_q;

	hs3d7_pkg::val_t t0_q, c_q, d_q;
	hs3d7_pkg::val_t a_rd, f_rd, b_rd, e_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q <= '0;
			rp_q <= '0;
		end else if (restart) begin
			pp_q <= '0;
			rp_q <= '0;
		end else if (adv) begin
			pp_q <= (pp_q == pl_last) ? '0 : pp_q + 1'b1;
			rp_q <= (rp_q == rw_last) ? '0 : rp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t0_q <= din;
			c_q  <= b_rd;
			d_q  <= c_q;
		end
	end

	// plane delay: newest cell into the j+1 tap, j-1 tap into the i-1 tap
	hs3d7_ram #(
		.WIDTH (2 * hs3d7_pkg::VAL_W),
		.DEPTH (PLANE_DEPTH)
	) u_plane_ram (
		.clk   (clk),
		.en    (adv),
		.we    (adv),
		.addr  (pp_q),
		.wdata ({t0_q, e_rd}),
		.rdata ({a_rd, f_rd})
	);

	// row delay: j+1 tap into the k+1 tap, k-1 tap into the j-1 tap
	hs3d7_ram #(
		.WIDTH (2 * hs3d7_pkg::VAL_W),
		.DEPTH (ROW_DEPTH)
	) u_row_ram (
		.clk   (clk),
		.en    (adv),
		.we    (adv),
		.addr  (rp_q),
		.wdata ({a_rd, d_q}),
		.rdata ({b_rd, e_rd})
	);

	assign taps.nb_ip = t0_q;
	assign taps.nb_jp = a_rd;
	assign taps.nb_kp = b_rd;
	assign taps.ctr   = c_q;
	assign taps.nb_km = d_q;
	assign taps.nb_jm = e_rd;
	assign taps.nb_im = f_rd;

	`HS3D7_ASSERT(a_ptr_in_range, clk, arst_n, (pp_q <= pl_last) && (rp_q <= rw_last), "window pointer past delay length")

endmodule

### rtl/hs3d7_sum.sv
// ----------------------------------------------------------------------------
// hs3d7_sum
// stencil adder pipeline and output register
// ----------------------------------------------------------------------------
`include "heat_stencil_3d_7pt_core_macros.svh"

module hs3d7_sum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hs3d7_pkg::taps_t     taps,
	input  hs3d7_pkg::meta_t     meta,
	output logic                 m_valid,
	input  logic                 m_ready,
	output hs3d7_pkg::val_t      m_value,
	output logic                 m_last
);

	logic                            v_s2;
	logic [hs3d7_pkg::PART_W-1:0]    sa_s2, sb_s2;
	hs3d7_pkg::val_t                 ctr_s2;
	hs3d7_pkg::meta_t                meta_s2;
	logic                            out_free, move1;
	logic [hs3d7_pkg::SUM_W-1:0]     total;

	assign out_free = !m_valid || m_ready;
	assign in_ready = !v_s2 || out_free;
	assign move1    = in_valid && in_ready;
	assign total    = {1'b0, sa_s2} + {1'b0, sb_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			m_valid <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s2 <= in_valid;
			end
			if (out_free) begin
				m_valid <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move1) begin
			sa_s2   <= {2'b00, taps.nb_ip} + {2'b00, taps.nb_jp}
				+ {2'b00, taps.nb_kp} + {2'b00, taps.nb_im};
			sb_s2   <= {1'b0, taps.ctr, 1'b0} + {2'b00, taps.nb_km} + {2'b00, taps.nb_jm};
			ctr_s2  <= taps.ctr;
			meta_s2 <= meta;
		end
		if (v_s2 && out_free) begin
			m_value <= meta_s2.interior ? total[hs3d7_pkg::SUM_W-1:3] : ctr_s2;
			m_last  <= meta_s2.last;
		end
	end

	`HS3D7_ASSERT_NEXT(a_s2_holds, clk, arst_n, v_s2 && m_valid && !m_ready, v_s2 && $stable(sa_s2) && $stable(sb_s2), "stalled stencil sum changed")

endmodule

### rtl/heat_stencil_3d_7pt_core.sv
// ----------------------------------------------------------------------------
// heat_stencil_3d_7pt_core
// one time step of a seven-point 3d jacobi heat stencil over a streamed cube
// ----------------------------------------------------------------------------
// a cube of E*E*E cells arrives on the slave stream in raster order (column
// fastest, then row, then plane), followed by E*E drain requests that push the
// last plane out. the block accepts one request per cycle; a request is taken
// every cycle as long as the output side drains, with two register stages of
// adders behind the window, through which the result of the request that
// completes its neighborhood reaches m_tvalid. results trail the input by one
// plane: the first E*E requests of a grid give no result, every later one gives
// exactly one. interior cells get (2*center + six neighbors) >> 3, boundary
// cells come out unchanged, and m_tlast marks the last cell of the grid, after
// which the next request starts a new grid. the window is two ram delay lines
// (one plane minus a row, one row) holding two planes plus one cell; they need
// no clearing pass, every tap used for a result holds a cell of the current
// grid. grid_edge is clamped to 3..MAX_EDGE, and writing it restarts the grid;
// write it only while the block is idle.
// ----------------------------------------------------------------------------
`include "heat_stencil_3d_7pt_core_macros.svh"

module heat_stencil_3d_7pt_core #(
	parameter int MAX_EDGE = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,

	// configuration: grid_edge
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hs3d7_pkg::CFG_W-1:0]  cfg_data,

	// input request stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [23:0]                  s_tdata,   // [23:0] cell_value
	input  logic [0:0]                   s_tuser,   // [0] req_type (1 = drain tick)

	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,   // [23:0] new_value
	output logic                         m_tlast    // last_of_grid
);

	localparam int E_W         = $clog2(MAX_EDGE + 1);
	localparam int P_W         = $clog2(MAX_EDGE * MAX_EDGE + 1);
	localparam int PLANE_DEPTH = MAX_EDGE * MAX_EDGE - MAX_EDGE - 1;
	localparam int ROW_DEPTH   = MAX_EDGE - 2;
	localparam int PA_W        = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
	localparam int RA_W        = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;

	// reset edge is 32, clamped like any written value
	localparam int RST_E = (MAX_EDGE < 32) ? MAX_EDGE : 32;
	localparam logic [6:0] MAX_E7 = 7'(MAX_EDGE);
	localparam logic [6:0] MIN_E7 = 7'd3;

	// edge-derived constants, all updated together on a register write
	logic [E_W-1:0]  edge_m1_q;   // E-1
	logic [P_W-1:0]  plane_q;     // E*E
	logic [PA_W-1:0] pl_last_q;   // plane delay length minus one
	logic [RA_W-1:0] rw_last_q;   // row delay length minus one

	// grid position of the next center cell
	logic [P_W-1:0]  fill_q;
	logic [E_W-1:0]  ci_q, cj_q, ck_q;

	// stage 1: taps in the window plus their control
	logic              v1_s1;
	hs3d7_pkg::meta_t  meta_s1;
	hs3d7_pkg::taps_t  taps;

	logic              s_acc, cfg_acc, sum_ready, emit;
	logic              ci_end, cj_end, ck_end, em_last, em_int;
	logic [6:0]        cfg_e7, cfg_cl7;
	logic [E_W-1:0]    e_new;
	logic [P_W-1:0]    p_new;
	hs3d7_pkg::val_t   din;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign s_tready  = !v1_s1 || sum_ready;
	assign s_acc     = s_tvalid && s_tready;

	// drain ticks enter the window as zero
	assign din = s_tuser[0] ? '0 : s_tdata;

	// clamp and square the written edge
	assign cfg_e7  = {1'b0, cfg_data};
	assign cfg_cl7 = (cfg_e7 < MIN_E7) ? MIN_E7 : ((cfg_e7 > MAX_E7) ? MAX_E7 : cfg_e7);
	assign e_new   = cfg_cl7[E_W-1:0];
	assign p_new   = P_W'(P_W'(e_new) * P_W'(e_new));

	// a result comes once a full plane sits ahead of the center
	assign emit    = (fill_q == plane_q);
	assign ci_end  = (ci_q == edge_m1_q);
	assign cj_end  = (cj_q == edge_m1_q);
	assign ck_end  = (ck_q == edge_m1_q);
	assign em_last = ci_end && cj_end && ck_end;
	assign em_int  = (ci_q != '0) && !ci_end && (cj_q != '0) && !cj_end
		&& (ck_q != '0) && !ck_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_m1_q <= E_W'(RST_E - 1);
			plane_q   <= P_W'(RST_E * RST_E);
			pl_last_q <= PA_W'(RST_E * RST_E - RST_E - 2);
			rw_last_q <= RA_W'(RST_E - 3);
			fill_q    <= '0;
			ci_q      <= '0;
			cj_q      <= '0;
			ck_q      <= '0;
			v1_s1     <= 1'b0;
		end else begin
			if (cfg_acc) begin
				edge_m1_q <= e_new - 1'b1;
				plane_q   <= p_new;
				pl_last_q <= PA_W'(p_new - P_W'(e_new) - P_W'(2));
				rw_last_q <= RA_W'(e_new - E_W'(3));
				fill_q    <= '0;
				ci_q      <= '0;
				cj_q      <= '0;
				ck_q      <= '0;
			end else if (s_acc) begin
				if (!emit) begin
					fill_q <= fill_q + 1'b1;
				end else if (em_last) begin
					// grid done, next request opens a new one
					fill_q <= '0;
					ci_q   <= '0;
					cj_q   <= '0;
					ck_q   <= '0;
				end else begin
					ck_q <= ck_end ? '0 : ck_q + 1'b1;
					if (ck_end) begin
						cj_q <= cj_end ? '0 : cj_q + 1'b1;
						if (cj_end) begin
							ci_q <= ci_q + 1'b1;
						end
					end
				end
			end

			if (s_acc) begin
				v1_s1 <= emit;
			end else if (sum_ready) begin
				v1_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			meta_s1.interior <= em_int;
			meta_s1.last     <= em_last;
		end
	end

	hs3d7_window #(
		.MAX_EDGE (MAX_EDGE)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (s_acc),
		.restart (cfg_acc),
		.pl_last (pl_last_q),
		.rw_last (rw_last_q),
		.din     (din),
		.taps    (taps)
	);

	hs3d7_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v1_s1),
		.in_ready (sum_ready),
		.taps     (taps),
		.meta     (meta_s1),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.m_value  (m_tdata),
		.m_last   (m_tlast)
	);

	`HS3D7_ASSERT(a_coord_range, clk, arst_n, (ci_q <= edge_m1_q) && (cj_q <= edge_m1_q) && (ck_q <= edge_m1_q), "grid coordinate past edge")
	`HS3D7_ASSERT_NEXT(a_no_result_in_fill, clk, arst_n, s_acc && !emit, !v1_s1, "result raised while the first plane fills")
	`HS3D7_ASSERT_NEXT(a_grid_restart, clk, arst_n, s_acc && emit && em_last, (fill_q == '0) && (ci_q == '0) && (cj_q == '0) && (ck_q == '0), "grid position not cleared after last cell")

endmodule
